>>> src/tss_pkg.sv
// Package for the tape saturation stereo chain: payload and register types,
// fixed-point helpers, sine/tanh tables and 48 kHz biquad coefficients.
// Depends on nothing; tss_delay, tss_core and the top level import it.
`default_nettype none
package tss_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int NOISE_BITS   = 16;
  localparam int DELAY_LENGTH = 64;
  localparam int DLY_AW       = $clog2(DELAY_LENGTH);
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 20;
  localparam int FS_WORDS     = 12;

  localparam logic signed [63:0] SIG_MAX = 64'sd134217727;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic [16:0]        MIX_FULL = 17'd65536;
  localparam logic [16:0]        WOW_MIN  = 17'd65;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DRIVE_MIX    = 3'd0,
    CFG_DRIVE_GAIN   = 3'd1,
    CFG_OUT_GAIN     = 3'd2,
    CFG_DC_BIAS      = 3'd3,
    CFG_DC_BIAS_SAT  = 3'd4,
    CFG_NOISE_LEVEL  = 3'd5,
    CFG_WOW_LFO_STEP = 3'd6,
    CFG_WOW_DEPTH    = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {C_B0, C_B1, C_B2, C_A1, C_A2} coef_sel_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic signed [NOISE_BITS-1:0]  noise_left;
    logic signed [NOISE_BITS-1:0]  noise_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [16:0] drive_mix;
    logic [15:0] drive_gain;
    logic [16:0] out_gain;
    logic [19:0] dc_bias;
    logic [19:0] dc_bias_sat;
    logic [11:0] noise_level;
    logic [15:0] wow_lfo_step;
    logic [12:0] wow_depth;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic take;
  } core_ctl_t;

  typedef struct packed {
    logic ready;
    logic done;
  } core_sts_t;

  typedef struct packed {
    logic                          we;
    logic                          ch;
    logic [DLY_AW-1:0]             waddr;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic [DLY_AW-1:0]             raddr;
  } dly_req_t;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                              input int unsigned n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [27:0] sat_sig(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > SIG_MAX) ? SIG_MAX : ((v < -SIG_MAX) ? -SIG_MAX : v);
    return t[27:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > 64'sd2147483647) ? 64'sd2147483647 :
        ((v < -64'sd2147483648) ? -64'sd2147483648 : v);
    return t[31:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
    return t[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [15:0] sine_tab(input logic [4:0] i);
    case (i)
      5'd0:  return 16'd0;
      5'd1:  return 16'd3212;
      5'd2:  return 16'd6393;
      5'd3:  return 16'd9512;
      5'd4:  return 16'd12540;
      5'd5:  return 16'd15447;
      5'd6:  return 16'd18205;
      5'd7:  return 16'd20788;
      5'd8:  return 16'd23170;
      5'd9:  return 16'd25330;
      5'd10: return 16'd27246;
      5'd11: return 16'd28899;
      5'd12: return 16'd30274;
      5'd13: return 16'd31357;
      5'd14: return 16'd32138;
      5'd15: return 16'd32610;
      5'd16: return 16'd32768;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] tanh_tab(input logic [5:0] i);
    case (i)
      6'd0:  return 16'd0;
      6'd1:  return 16'd8150;
      6'd2:  return 16'd16051;
      6'd3:  return 16'd23485;
      6'd4:  return 16'd30285;
      6'd5:  return 16'd36346;
      6'd6:  return 16'd41625;
      6'd7:  return 16'd46131;
      6'd8:  return 16'd49911;
      6'd9:  return 16'd53038;
      6'd10: return 16'd55593;
      6'd11: return 16'd57660;
      6'd12: return 16'd59320;
      6'd13: return 16'd60644;
      6'd14: return 16'd61694;
      6'd15: return 16'd62524;
      6'd16: return 16'd63178;
      6'd17: return 16'd63693;
      6'd18: return 16'd64096;
      6'd19: return 16'd64412;
      6'd20: return 16'd64659;
      6'd21: return 16'd64852;
      6'd22: return 16'd65003;
      6'd23: return 16'd65120;
      6'd24: return 16'd65212;
      6'd25: return 16'd65283;
      6'd26: return 16'd65339;
      6'd27: return 16'd65383;
      6'd28: return 16'd65417;
      6'd29: return 16'd65443;
      6'd30: return 16'd65464;
      6'd31: return 16'd65480;
      6'd32: return 16'd65492;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] coef(input logic [1:0] stage, input coef_sel_t k);
    logic signed [31:0] c;
    c = 32'sd0;
    case (stage)
      2'd0: begin
        case (k)
          C_B0: c = 32'sd1076474228;
          C_B1: c = -32'sd2131831080;
          C_B2: c = 32'sd1055473750;
          C_A1: c = -32'sd2131831080;
          C_A2: c = 32'sd1058206165;
          default: c = 32'sd0;
        endcase
      end
      2'd1: begin
        case (k)
          C_B0: c = 32'sd1106211734;
          C_B1: c = -32'sd1692747333;
          C_B2: c = 32'sd724120534;
          C_A1: c = -32'sd1692747333;
          C_A2: c = 32'sd756590455;
          default: c = 32'sd0;
        endcase
      end
      2'd2: begin
        case (k)
          C_B0: c = 32'sd356805546;
          C_B1: c = 32'sd713611092;
          C_B2: c = 32'sd356805546;
          C_A1: c = 32'sd164781562;
          C_A2: c = 32'sd188698612;
          default: c = 32'sd0;
        endcase
      end
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/tss_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing beyond its ports.
`default_nettype none
module tss_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [29:0] b,
  output logic signed [61:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= 62'(a) * 62'(b);
  end

endmodule
`default_nettype wire

>>> src/tss_delay.sv
// Left and right wow delay lines: one write and one registered read a cycle.
// Depends on tss_pkg for widths and the request struct.
`default_nettype none
module tss_delay
  import tss_pkg::*;
(
  input  wire logic                     clk,
  input  wire dly_req_t                 req,
  output logic signed [SAMPLE_BITS-1:0] rdata_r
);

  logic signed [SAMPLE_BITS-1:0] mem_l [DELAY_LENGTH];
  logic signed [SAMPLE_BITS-1:0] mem_r [DELAY_LENGTH];

  always_ff @(posedge clk) begin
    if (req.we && !req.ch) begin
      mem_l[req.waddr] <= req.wdata;
    end
    if (req.we && req.ch) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= req.ch ? mem_r[req.raddr] : mem_l[req.raddr];
  end

endmodule
`default_nettype wire

>>> src/tss_core.sv
// Frame sequencer and datapath around the shared multiplier: LFO, wow read,
// biquads, waveshaper and noise. Depends on tss_pkg, tss_mul and tss_delay.
`default_nettype none
module tss_core
  import tss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire core_ctl_t ctl,
  input  wire in_item_t  in_item,
  input  wire cfg_t      cfg,
  output core_sts_t      sts,
  output out_item_t      res
);

  typedef enum logic [4:0] {
    S_IDLE, S_PH, S_SN_M, S_SN_A, S_CH,
    S_W0_M, S_W0_A, S_RD0, S_RD1, S_RD2, S_WF,
    S_B0_M, S_B0_A, S_B1_M, S_B2_M, S_B3_M, S_B4_M, S_B4_A,
    S_T0_M, S_T0_A, S_T1_M, S_T1_A, S_T2_M, S_T2_A, S_T3_M, S_T3_A,
    S_N_M, S_N_A, S_DONE
  } state_t;

  state_t                        state_r;
  logic                          ch_r;
  logic [1:0]                    st_r;
  logic [DLY_AW-1:0]             wi_r;
  logic                          wrap_r;
  logic [31:0]                   phase_r;
  logic signed [16:0]            sn_r;
  logic signed [27:0]            x_r;
  logic signed [27:0]            y_r;
  logic signed [63:0]            acc_r;
  logic [DLY_AW+7:0]             pos_r;
  logic                          rvld_r;
  logic signed [31:0]            fs_r [FS_WORDS];
  logic                          tbig_r;
  logic                          tneg_r;
  logic [4:0]                    tidx_r;
  logic [15:0]                   tfrac_r;
  logic signed [25:0]            th_r;
  logic signed [29:0]            d_r;
  in_item_t                      in_r;
  out_item_t                     res_r;

  logic signed [31:0]            mul_a;
  logic signed [29:0]            mul_b;
  logic signed [61:0]            mul_p;
  logic signed [63:0]            pw;
  dly_req_t                      dreq;
  logic signed [SAMPLE_BITS-1:0] dly_q;
  logic signed [SAMPLE_BITS-1:0] rd;
  logic [DLY_AW-1:0]             rd_addr;
  logic [3:0]                    fsb;
  logic [3:0]                    fs_ra;
  logic signed [31:0]            fs_rd;
  logic [16:0]                   mix;
  logic                          wow;
  logic [30:0]                   sw0;
  logic [30:0]                   sw;
  logic [4:0]                    sidx;
  logic [15:0]                   sfrac;
  logic signed [16:0]            sdiff;
  logic signed [16:0]            tdiff;
  logic signed [SAMPLE_BITS-1:0] xin;
  logic signed [NOISE_BITS-1:0]  nin;
  logic signed [63:0]            ta;
  logic signed [63:0]            sv;
  logic signed [63:0]            tv;

  tss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  tss_delay u_dly (
    .clk     (clk),
    .req     (dreq),
    .rdata_r (dly_q)
  );

  assign pw    = 64'(mul_p);
  assign rd    = rvld_r ? dly_q : '0;
  assign mix   = (cfg.drive_mix > MIX_FULL) ? MIX_FULL : cfg.drive_mix;
  assign wow   = mix > WOW_MIN;
  assign xin   = ch_r ? in_r.right_in : in_r.left_in;
  assign nin   = ch_r ? in_r.noise_right : in_r.noise_left;
  assign fsb   = (ch_r ? 4'd6 : 4'd0) + {1'b0, st_r, 1'b0};
  assign fs_ra = (state_r == S_B3_M) ? (fsb + 4'd1) : fsb;
  assign fs_rd = fs_r[fs_ra];

  // Quarter-wave sine lookup from the phase accumulator.
  assign sw0   = {1'b0, phase_r[29:0]};
  assign sw    = phase_r[30] ? (31'h4000_0000 - sw0) : sw0;
  assign sidx  = sw[30:26];
  assign sfrac = sw[25:10];
  assign sdiff = $signed({1'b0, sine_tab(sidx + 5'd1)}) - $signed({1'b0, sine_tab(sidx)});
  assign tdiff = $signed({1'b0, tanh_tab({1'b0, tidx_r} + 6'd1)})
               - $signed({1'b0, tanh_tab({1'b0, tidx_r})});
  assign ta    = pw[63] ? -pw : pw;
  assign sv    = (sidx >= 5'd16) ? 64'sd32768 : ($signed(64'(sine_tab(sidx))) + rnd(pw, 16));
  assign tv    = tbig_r ? (64'sd1 <<< 23)
               : ($signed(64'(tanh_tab({1'b0, tidx_r})) <<< 7) + rnd(pw, 9));

  assign rd_addr = (state_r == S_RD1) ? (pos_r[DLY_AW+7:8] + 1'b1) : pos_r[DLY_AW+7:8];

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    dreq.we    = 1'b0;
    dreq.ch    = ch_r;
    dreq.waddr = wi_r;
    dreq.wdata = xin;
    dreq.raddr = rd_addr;
    case (state_r)
      S_SN_M: begin
        mul_a = 32'(sdiff);
        mul_b = {14'b0, sfrac};
      end
      S_CH: begin
        dreq.we = 1'b1;
      end
      S_W0_M: begin
        mul_a = {19'b0, cfg.wow_depth};
        mul_b = 30'(sn_r);
      end
      S_RD1: begin
        mul_a = 32'(rd);
        mul_b = {21'b0, 9'd256 - {1'b0, pos_r[7:0]}};
      end
      S_RD2: begin
        mul_a = 32'(rd);
        mul_b = {22'b0, pos_r[7:0]};
      end
      S_B0_M: begin
        mul_a = coef(st_r, C_B0);
        mul_b = 30'(x_r);
      end
      S_B1_M: begin
        mul_a = coef(st_r, C_B1);
        mul_b = 30'(x_r);
      end
      S_B2_M: begin
        mul_a = coef(st_r, C_A1);
        mul_b = 30'(y_r);
      end
      S_B3_M: begin
        mul_a = coef(st_r, C_B2);
        mul_b = 30'(x_r);
      end
      S_B4_M: begin
        mul_a = coef(st_r, C_A2);
        mul_b = 30'(y_r);
      end
      S_T0_M: begin
        mul_a = {16'b0, cfg.drive_gain};
        mul_b = 30'(x_r) + {10'b0, cfg.dc_bias};
      end
      S_T1_M: begin
        mul_a = 32'(tdiff);
        mul_b = {14'b0, tfrac_r};
      end
      S_T2_M: begin
        mul_a = {15'b0, cfg.out_gain};
        mul_b = 30'(th_r);
      end
      S_T3_M: begin
        mul_a = {15'b0, mix};
        mul_b = d_r;
      end
      S_N_M: begin
        mul_a = {20'b0, cfg.noise_level};
        mul_b = 30'(nin);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 1'b0;
      st_r    <= 2'd0;
      wi_r    <= '0;
      wrap_r  <= 1'b0;
      phase_r <= '0;
      for (int i = 0; i < FS_WORDS; i++) begin
        fs_r[i] <= '0;
      end
    end else begin
      rvld_r <= wrap_r || (rd_addr <= wi_r);
      case (state_r)
        S_IDLE: begin
          if (ctl.start) begin
            in_r    <= in_item;
            state_r <= S_PH;
          end
        end
        S_PH: begin
          phase_r <= phase_r + {16'b0, cfg.wow_lfo_step};
          ch_r    <= 1'b0;
          state_r <= S_SN_M;
        end
        S_SN_M: state_r <= S_SN_A;
        S_SN_A: begin
          sn_r    <= 17'(phase_r[31] ? -sv : sv);
          state_r <= S_CH;
        end
        S_CH: begin
          x_r     <= 28'(xin);
          st_r    <= 2'd0;
          state_r <= wow ? S_W0_M : S_B0_M;
        end
        S_W0_M: state_r <= S_W0_A;
        S_W0_A: begin
          pos_r   <= (DLY_AW+8)'(64'({wi_r, 8'b0}) - 64'sd256 - 64'(cfg.wow_depth)
                     - rnd(pw, 15));
          state_r <= S_RD0;
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          acc_r   <= pw;
          state_r <= S_WF;
        end
        S_WF: begin
          x_r     <= 28'(rnd(acc_r + pw, 8));
          state_r <= S_B0_M;
        end
        S_B0_M: state_r <= S_B0_A;
        S_B0_A: begin
          y_r     <= sat_sig(64'(fs_rd) + rnd(pw, 30));
          state_r <= S_B1_M;
        end
        S_B1_M: state_r <= S_B2_M;
        S_B2_M: begin
          acc_r   <= pw;
          state_r <= S_B3_M;
        end
        S_B3_M: begin
          fs_r[fsb] <= sat32(64'(fs_rd) + rnd(acc_r - pw, 30));
          state_r   <= S_B4_M;
        end
        S_B4_M: begin
          acc_r   <= pw;
          state_r <= S_B4_A;
        end
        S_B4_A: begin
          fs_r[fsb + 4'd1] <= sat32(rnd(acc_r - pw, 30));
          x_r              <= y_r;
          case (st_r)
            2'd0: begin
              st_r    <= 2'd1;
              state_r <= S_B0_M;
            end
            2'd1: state_r <= S_T0_M;
            default: state_r <= S_N_M;
          endcase
        end
        S_T0_M: state_r <= S_T0_A;
        S_T0_A: begin
          tbig_r  <= ta[63:38] != '0;
          tidx_r  <= ta[37:33];
          tfrac_r <= ta[32:17];
          tneg_r  <= pw[63];
          state_r <= S_T1_M;
        end
        S_T1_M: state_r <= S_T1_A;
        S_T1_A: begin
          th_r    <= 26'((tneg_r ? -tv : tv) - 64'(cfg.dc_bias_sat));
          state_r <= S_T2_M;
        end
        S_T2_M: state_r <= S_T2_A;
        S_T2_A: begin
          d_r     <= 30'(rnd(pw, 16) - 64'(x_r));
          state_r <= S_T3_M;
        end
        S_T3_M: state_r <= S_T3_A;
        S_T3_A: begin
          x_r     <= sat_sig(64'(x_r) + rnd(pw, 16));
          st_r    <= 2'd2;
          state_r <= S_B0_M;
        end
        S_N_M: state_r <= S_N_A;
        S_N_A: begin
          if (ch_r) begin
            res_r.right_out <= sat_out(64'(x_r) + rnd(pw, 16));
            state_r         <= S_DONE;
          end else begin
            res_r.left_out <= sat_out(64'(x_r) + rnd(pw, 16));
            ch_r           <= 1'b1;
            state_r        <= S_CH;
          end
        end
        S_DONE: begin
          if (ctl.take) begin
            wi_r    <= wi_r + 1'b1;
            if (wi_r == DLY_AW'(DELAY_LENGTH - 1)) begin
              wrap_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign sts.ready = (state_r == S_IDLE);
  assign sts.done  = (state_r == S_DONE);
  assign res       = res_r;

endmodule
`default_nettype wire

>>> src/tape_saturation_stereo_chain_top.sv
// Top level of the tape saturation stereo chain: handshakes, configuration
// registers and the output register. Depends on tss_pkg and tss_core.
//
//   Channel   Ports                           Moves
//   input     in_valid, in_stall, in_data     one stereo frame plus noise
//   result    out_valid, out_stall, out_data  one processed stereo frame
//   config    cfg_we, cfg_addr, cfg_wdata     one register write
//
// The single shared multiplier is stepped through every product of the LFO,
// wow read, three biquads per channel, the waveshaper and the noise term, so a
// frame takes longer with wow on than with wow off. Reset is synchronous and
// clears the delay fill state, LFO phase, biquad state and registers to their
// defaults. A finished frame waits in the output register while the next one
// is taken in and worked on; the core holds a second result until it drains.
`default_nettype none
module tape_saturation_stereo_chain_top
  import tss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  core_ctl_t ctl;
  core_sts_t sts;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;

  // Configuration registers; software must write them only while the block idles; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_mix    <= 17'd0;
      cfg_r.drive_gain   <= 16'd8192;
      cfg_r.out_gain     <= 17'd65536;
      cfg_r.dc_bias      <= 20'd1006633;
      cfg_r.dc_bias_sat  <= 20'd1001870;
      cfg_r.noise_level  <= 12'd266;
      cfg_r.wow_lfo_step <= 16'd4474;
      cfg_r.wow_depth    <= 13'd3686;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DRIVE_MIX:    cfg_r.drive_mix    <= cfg_wdata[16:0];
        CFG_DRIVE_GAIN:   cfg_r.drive_gain   <= cfg_wdata[15:0];
        CFG_OUT_GAIN:     cfg_r.out_gain     <= cfg_wdata[16:0];
        CFG_DC_BIAS:      cfg_r.dc_bias      <= cfg_wdata[19:0];
        CFG_DC_BIAS_SAT:  cfg_r.dc_bias_sat  <= cfg_wdata[19:0];
        CFG_NOISE_LEVEL:  cfg_r.noise_level  <= cfg_wdata[11:0];
        CFG_WOW_LFO_STEP: cfg_r.wow_lfo_step <= cfg_wdata[15:0];
        CFG_WOW_DEPTH:    cfg_r.wow_depth    <= cfg_wdata[12:0];
        default:          cfg_r.drive_mix    <= cfg_r.drive_mix;
      endcase
    end
  end

  // The core takes a frame only from its idle state.
  assign in_stall  = !sts.ready;
  assign ctl.start = in_valid && sts.ready;
  // A finished frame moves to the output register when that register is free
  // or is being emptied by a transfer in the same cycle.
  assign ctl.take  = sts.done && (!out_valid_r || !out_stall);

  tss_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_item (in_data),
    .cfg     (cfg_r),
    .sts     (sts),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.take) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The core is never idle and holding a result at once.
  assert property (@(posedge clk) disable iff (!rst_n) !(sts.ready && sts.done))
    else $error("core idle while holding a result");

  // Handing over a result returns the core to idle.
  assert property (@(posedge clk) disable iff (!rst_n) ctl.take |=> sts.ready)
    else $error("core not idle after result handover");

  // A new result shows up only right after a handover from the core.
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(ctl.take))
    else $error("output valid without a handover");

  // Starting a frame leaves the core busy.
  assert property (@(posedge clk) disable iff (!rst_n) ctl.start |=> !sts.ready)
    else $error("core still idle after accepting a frame");

endmodule
`default_nettype wire
